// ----- rtl/core/ltsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ltsc_pkg;

	localparam int LTSC_TOKEN_MAX = 32;

	// Characters with a role of their own.
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_BSL   = 8'h5c;

	// Token kind codes on the result port.
	localparam logic [2:0] TK_SYMBOL = 3'd0;
	localparam logic [2:0] TK_NUMBER = 3'd1;
	localparam logic [2:0] TK_OPEN   = 3'd2;
	localparam logic [2:0] TK_CLOSE  = 3'd3;
	localparam logic [2:0] TK_QUOTE  = 3'd4;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_SYM  = 2'd1,
		KIND_NUM  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_SYM    = 2'd1,
		ACT_NUM    = 2'd2,
		ACT_SINGLE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_FLUSH  = 2'd1,
		ST_SINGLE = 2'd2
	} state_t;

	typedef struct packed {
		logic       shift;
		logic       load;
		logic [7:0] data;
	} chain_ctrl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	// Letters and the operator characters + * / % ! ? & ^ | < >.
	function automatic logic sym_start(input logic [7:0] c);
		return c inside {[8'h41:8'h5a], [8'h61:8'h7a], 8'h2b, 8'h2a, 8'h2f, 8'h25,
			8'h21, 8'h3f, 8'h26, 8'h5e, 8'h7c, 8'h3c, 8'h3e};
	endfunction

	function automatic logic sym_more(input logic [7:0] c);
		return sym_start(c) || (c == CH_MINUS) || (c == CH_BSL);
	endfunction

	function automatic act_t classify(input logic [7:0] c);
		act_t a;
		a = ACT_NONE;
		if (sym_start(c)) begin
			a = ACT_SYM;
		end else if (is_digit(c) || (c == CH_MINUS)) begin
			a = ACT_NUM;
		end else if ((c == CH_OPEN) || (c == CH_CLOSE) || (c == CH_QUOTE)) begin
			a = ACT_SINGLE;
		end
		return a;
	endfunction

	function automatic logic [2:0] single_code(input logic [7:0] c);
		logic [2:0] k;
		case (c)
			CH_OPEN:  k = TK_OPEN;
			CH_CLOSE: k = TK_CLOSE;
			default:  k = TK_QUOTE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ltsc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ltsc_cell (
	input  logic                    clk,
	input  ltsc_pkg::chain_ctrl_t   ctrl,
	input  logic                    sel,
	input  logic [7:0]              nbr,
	output logic [7:0]              data_q
);
	import ltsc_pkg::*;

	// A write into this cell wins over the shift toward the head.
	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			data_q <= ctrl.data;
		end else if (ctrl.shift) begin
			data_q <= nbr;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ltsc_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ltsc_chain #(
	parameter int TOKEN_MAX = ltsc_pkg::LTSC_TOKEN_MAX,
	localparam int IDX_W = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1
) (
	input  logic                    clk,
	input  ltsc_pkg::chain_ctrl_t   ctrl,
	input  logic [IDX_W-1:0]        idx,
	output logic [7:0]              head
);
	import ltsc_pkg::*;

	logic [7:0] cell_data [TOKEN_MAX];

	for (genvar i = 0; i < TOKEN_MAX; i++) begin : g_cell
		logic [7:0] nbr;
		if (i == TOKEN_MAX - 1) begin : g_tail
			assign nbr = 8'h00;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		ltsc_cell u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.sel    (idx == IDX_W'(i)),
			.nbr    (nbr),
			.data_q (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

`default_nettype wire

// ----- rtl/core/lisp_token_scanner_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A byte that extends the token in progress is taken and gives no result.
// A byte that ends a token of n kept characters starts n results, the first in the cycle
// after it is taken, one a cycle while m_tready is high; a paren or quote adds one more.
// The chain of character cells drains one character per cycle toward its head while
// m_tready is high, and no byte is taken while it drains.
// arst_n clears the token state and the controller; the character cells are not reset.

module lisp_token_scanner_core #(
	parameter int TOKEN_MAX = ltsc_pkg::LTSC_TOKEN_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tlast,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] char_out
	output logic        m_tlast,   // last_of_token
	output logic [3:0]  m_tuser    // [2:0] token_kind, [3] truncated
);
	import ltsc_pkg::*;

	localparam int LEN_W = $clog2(TOKEN_MAX + 1);
	localparam int IDX_W = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;

	state_t           state_q, state_d;
	kind_t            kind_q, kind_d;
	logic             dot_q, dot_d;
	logic             ovf_q, ovf_d;
	logic [LEN_W-1:0] len_q, len_d;
	act_t             pend_act_q, pend_act_d;
	logic [7:0]       pend_char_q, pend_char_d;
	logic [2:0]       single_kind_q, single_kind_d;
	logic [7:0]       single_char_q, single_char_d;

	chain_ctrl_t      cctrl;
	logic [IDX_W-1:0] cidx;
	logic [7:0]       head;

	logic in_acc, out_acc, flush_done, pending, extend, start_en;
	act_t in_act, start_act;
	logic [7:0] start_char;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign pending = ((kind_q == KIND_SYM) || (kind_q == KIND_NUM)) && (len_q != '0);
	assign extend  = !s_tlast && (((kind_q == KIND_SYM) && sym_more(s_tdata)) ||
		((kind_q == KIND_NUM) && (is_digit(s_tdata) || ((s_tdata == CH_DOT) && !dot_q))));
	assign in_act  = s_tlast ? ACT_NONE : classify(s_tdata);
	assign flush_done = (state_q == ST_FLUSH) && out_acc && (len_q == LEN_W'(1));

	// Start of a fresh token, either straight from the input or once a flush ends.
	always_comb begin
		start_en   = 1'b0;
		start_act  = in_act;
		start_char = s_tdata;
		if (flush_done) begin
			start_en   = 1'b1;
			start_act  = pend_act_q;
			start_char = pend_char_q;
		end else if ((state_q == ST_IDLE) && in_acc && !extend && !pending) begin
			start_en = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && !extend) begin
					if (pending) begin
						state_d = ST_FLUSH;
					end else if (start_act == ACT_SINGLE) begin
						state_d = ST_SINGLE;
					end
				end
			end
			ST_FLUSH: begin
				if (flush_done) begin
					state_d = (start_act == ACT_SINGLE) ? ST_SINGLE : ST_IDLE;
				end
			end
			ST_SINGLE: begin
				if (out_acc) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_FLUSH) || (state_q == ST_SINGLE);
		if (state_q == ST_FLUSH) begin
			m_tdata = head;
			m_tlast = (len_q == LEN_W'(1));
			m_tuser = {ovf_q, (kind_q == KIND_SYM) ? TK_SYMBOL : TK_NUMBER};
		end else begin
			m_tdata = single_char_q;
			m_tlast = 1'b1;
			m_tuser = {1'b0, single_kind_q};
		end
	end

	// Token state and chain control.
	always_comb begin
		kind_d        = kind_q;
		dot_d         = dot_q;
		ovf_d         = ovf_q;
		len_d         = len_q;
		pend_act_d    = pend_act_q;
		pend_char_d   = pend_char_q;
		single_kind_d = single_kind_q;
		single_char_d = single_char_q;
		cctrl.shift   = 1'b0;
		cctrl.load    = 1'b0;
		cctrl.data    = s_tdata;
		cidx          = len_q[IDX_W-1:0];

		if ((state_q == ST_IDLE) && in_acc) begin
			if (extend) begin
				if ((kind_q == KIND_NUM) && (s_tdata == CH_DOT)) begin
					dot_d = 1'b1;
				end
				if (len_q < LEN_W'(TOKEN_MAX)) begin
					cctrl.load = 1'b1;
					len_d      = len_q + LEN_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end else if (pending) begin
				pend_act_d  = in_act;
				pend_char_d = s_tdata;
			end
		end

		if ((state_q == ST_FLUSH) && out_acc) begin
			cctrl.shift = 1'b1;
			len_d       = len_q - LEN_W'(1);
		end

		if (start_en) begin
			dot_d         = 1'b0;
			ovf_d         = 1'b0;
			kind_d        = KIND_NONE;
			len_d         = '0;
			single_char_d = start_char;
			single_kind_d = single_code(start_char);
			if ((start_act == ACT_SYM) || (start_act == ACT_NUM)) begin
				kind_d     = (start_act == ACT_SYM) ? KIND_SYM : KIND_NUM;
				len_d      = LEN_W'(1);
				cctrl.load = 1'b1;
				cctrl.data = start_char;
				cidx       = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= KIND_NONE;
			dot_q      <= 1'b0;
			ovf_q      <= 1'b0;
			len_q      <= '0;
			pend_act_q <= ACT_NONE;
		end else begin
			state_q    <= state_d;
			kind_q     <= kind_d;
			dot_q      <= dot_d;
			ovf_q      <= ovf_d;
			len_q      <= len_d;
			pend_act_q <= pend_act_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_char_q   <= pend_char_d;
		single_kind_q <= single_kind_d;
		single_char_q <= single_char_d;
	end

	ltsc_chain #(
		.TOKEN_MAX (TOKEN_MAX)
	) u_chain (
		.clk  (clk),
		.ctrl (cctrl),
		.idx  (cidx),
		.head (head)
	);

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (len_q != '0))
		else $error("flush with no characters kept");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while results are pending");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(TOKEN_MAX))
		else $error("token length beyond buffer");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && (state_q == ST_IDLE)) |-> (len_q == LEN_W'(TOKEN_MAX)))
		else $error("overflow flagged on a buffer that is not full");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SINGLE) && out_acc) |=> (state_q == ST_IDLE))
		else $error("single-character token not retired");

endmodule

`default_nettype wire
